FILE: sv/gmm_gaussian_constant_defines.svh
// Assertion macros for the Gaussian constant block.
// Used by the top level; relies on aclk and aresetn in the including scope.
`ifndef GMM_GAUSSIAN_CONSTANT_DEFINES_SVH
`define GMM_GAUSSIAN_CONSTANT_DEFINES_SVH
`ifndef SYNTHESIS
`define GMMGC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define GMMGC_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define GMMGC_ASSERT(label, prop, msg)
`define GMMGC_ASSERT_NEXT(label, cond, conseq, msg)
`endif
`endif

FILE: sv/gmmgc_pkg.sv
// Types, constants and saturation helpers of the Gaussian constant block.
// No dependencies.
package gmmgc_pkg;

    localparam int LOG_FRAC = 28;
    localparam logic [31:0] LN2_Q30 = 32'd744261118;
    localparam logic [31:0] HALF_LN_2PI_Q32 = 32'd3946810947;
    localparam logic signed [63:0] ACC_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN64 = 64'shFFFF_8000_0000_0000;
    localparam logic signed [47:0] ACC_MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN48 = 48'sh8000_0000_0000;

    typedef struct packed {
        logic              first_elem;
        logic              last_elem;
        logic [31:0]       mix_weight;
        logic [31:0]       inv_variance;
        logic signed [31:0] mean_times_invvar;
    } gmmgc_in_t;

    typedef struct packed {
        logic signed [31:0] gauss_const;
        logic              minus_inf;
        logic [15:0]       component_index;
    } gmmgc_out_t;

    typedef enum logic [3:0] {
        S_IDLE, S_OFFSET, S_VCHECK, S_NORM, S_SQUARE, S_MUL_LO, S_MUL_HI,
        S_LN_ADD, S_MAG_SQ, S_DIVIDE, S_QUAD_ADD, S_FINISH
    } gmmgc_state_t;

    function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > ACC_MAX64) r = ACC_MAX48;
        else if (v < ACC_MIN64) r = ACC_MIN48;
        else r = v[47:0];
        return r;
    endfunction

    function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                     input logic signed [47:0] b);
        logic signed [48:0] s;
        logic signed [47:0] r;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47]) r = s[48] ? ACC_MIN48 : ACC_MAX48;
        else r = s[47:0];
        return r;
    endfunction

endpackage

FILE: sv/gmm_gaussian_constant.sv
// Top level of the diagonal-Gaussian log normaliser (gconst).
// Depends on gmmgc_pkg, gmmgc_mul and gmm_gaussian_constant_defines.svh.
//
//  channel | ports                      | direction | moves
//  --------+----------------------------+-----------+-------------------------
//  input   | s_valid s_ready s_data     | in        | one element item
//  result  | m_valid m_ready m_data     | out       | one constant per component
//  config  | cfg_valid cfg_ready cfg_data | in      | feature_dim
//
// The shortest item is a later element with a zero inverse variance, the longest a
// first element whose weight and inverse variance each need 31 normalising shifts.
// Each logarithm needs up to 31 normalising shifts plus 28 squarings through the
// one shared multiplier, and the quadratic term runs a radix-2 divider.
// s_ready is high only in the idle state.
// Reset (aresetn low, synchronous) clears the sums, the flag, the counter and sets
// feature_dim to 39. A result that has not been taken holds the block back before
// it can overwrite the output register; configuration is always accepted.
`include "gmm_gaussian_constant_defines.svh"
module gmm_gaussian_constant
    import gmmgc_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAX_DIM = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  gmmgc_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output gmmgc_out_t m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    // Dimension cap; feature_dim above it is taken as the cap.
    localparam logic [7:0] DIM_CAP = (MAX_DIM > 255) ? 8'd255 : 8'(MAX_DIM);
    localparam int OFF_SHIFT = 32 - FRAC_BITS;
    localparam int W_SHIFT = 58 - FRAC_BITS;
    localparam int V_SHIFT = 59 - FRAC_BITS;
    localparam logic [63:0] OFF_RND = 64'd1 << (OFF_SHIFT - 1);
    localparam logic signed [63:0] W_RND = 64'sd1 <<< (W_SHIFT - 1);
    localparam logic signed [63:0] V_RND = 64'sd1 <<< (V_SHIFT - 1);
    localparam logic signed [6:0] FB_W = 7'sd32;
    localparam logic signed [6:0] FB_V = 7'(FRAC_BITS);
    localparam logic [5:0] SQ_LAST = 6'(LOG_FRAC - 1);
    localparam logic [5:0] DIV_LAST = 6'd62;

    gmmgc_state_t       state_reg, state_next;
    gmmgc_in_t          in_reg, in_next;
    logic [7:0]         dim_reg, dim_next;
    logic signed [47:0] acc_reg, acc_next;
    logic               inf_reg, inf_next;
    logic [15:0]        comp_reg, comp_next;
    logic [31:0]        m_reg, m_next;
    logic [4:0]         e_reg, e_next;
    logic [27:0]        frac_reg, frac_next;
    logic [5:0]         step_reg, step_next;
    logic               sel_reg, sel_next;   // 0: weight log, 1: variance log
    logic [63:0]        prod_reg, prod_next;
    logic signed [63:0] lnv_reg, lnv_next;
    logic [62:0]        num_reg, num_next;
    logic [32:0]        rem_reg, rem_next;
    logic [32:0]        den_reg, den_next;
    gmmgc_out_t         out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    gmmgc_mul u_mul (.op_a(mul_a), .op_b(mul_b), .product(mul_p));

    // Log as a signed fixed-point value: integer part from the leading one,
    // 28 fraction bits from the squarings.
    logic signed [6:0]  log_int;
    logic signed [34:0] log_fix;
    logic [34:0]        log_mag;
    logic [63:0]        ln_full;
    logic [32:0]        sq_shift;
    logic [31:0]        mag;
    logic [33:0]        trial;
    logic [63:0]        off;
    logic signed [63:0] rnd;
    logic signed [47:0] quad;

    always_comb begin
        log_int = $signed({2'b00, e_reg}) - (sel_reg ? FB_V : FB_W);
        log_fix = {log_int, frac_reg};
        log_mag = log_int[6] ? 35'(-log_fix) : 35'(log_fix);
        sq_shift = mul_p[63:31];
        mag = in_reg.mean_times_invvar[31] ? 32'(-in_reg.mean_times_invvar)
                                           : 32'(in_reg.mean_times_invvar);
        trial = {rem_reg, num_reg[62]};
        ln_full = prod_reg + (mul_p << 17);
        off = (prod_reg + OFF_RND) >> OFF_SHIFT;
        rnd = sel_reg ? ((lnv_reg + V_RND) >>> V_SHIFT) : ((lnv_reg + W_RND) >>> W_SHIFT);
        quad = (num_reg > 63'(ACC_MAX48)) ? ACC_MAX48 : $signed(num_reg[47:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            dim_reg <= 8'd39;
            acc_reg <= '0;
            inf_reg <= 1'b0;
            comp_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            dim_reg <= dim_next;
            acc_reg <= acc_next;
            inf_reg <= inf_next;
            comp_reg <= comp_next;
            out_valid_reg <= out_valid_next;
        end
        in_reg <= in_next;
        m_reg <= m_next;
        e_reg <= e_next;
        frac_reg <= frac_next;
        step_reg <= step_next;
        sel_reg <= sel_next;
        prod_reg <= prod_next;
        lnv_reg <= lnv_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        out_reg <= out_next;
    end

    always_comb begin
        state_next = state_reg;
        in_next = in_reg;
        dim_next = dim_reg;
        acc_next = acc_reg;
        inf_next = inf_reg;
        comp_next = comp_reg;
        m_next = m_reg;
        e_next = e_reg;
        frac_next = frac_reg;
        step_next = step_reg;
        sel_next = sel_reg;
        prod_next = prod_reg;
        lnv_next = lnv_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        mul_a = '0;
        mul_b = '0;

        if (cfg_valid) begin
            dim_next = cfg_data;
        end
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next = s_data;
                    state_next = s_data.first_elem ? S_OFFSET : S_VCHECK;
                end
            end
            S_OFFSET: begin
                // Product registered here; the offset is applied below from prod_reg.
                mul_a = HALF_LN_2PI_Q32;
                mul_b = {24'd0, (dim_reg > DIM_CAP) ? DIM_CAP : dim_reg};
                prod_next = mul_p;
                state_next = S_LN_ADD;
                sel_next = 1'b0;
                step_next = '1;   // marks the offset pass through S_LN_ADD
            end
            S_VCHECK: begin
                if (in_reg.inv_variance == 32'd0) begin
                    inf_next = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    m_next = in_reg.inv_variance;
                    e_next = 5'd31;
                    sel_next = 1'b1;
                    state_next = S_NORM;
                end
            end
            S_NORM: begin
                if (m_reg[31]) begin
                    step_next = '0;
                    frac_next = '0;
                    state_next = S_SQUARE;
                end else begin
                    m_next = {m_reg[30:0], 1'b0};
                    e_next = e_reg - 5'd1;
                end
            end
            S_SQUARE: begin
                mul_a = m_reg;
                mul_b = m_reg;
                if (sq_shift[32]) begin
                    m_next = sq_shift[32:1];
                    frac_next = {frac_reg[26:0], 1'b1};
                end else begin
                    m_next = sq_shift[31:0];
                    frac_next = {frac_reg[26:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == SQ_LAST) begin
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                mul_a = {15'd0, log_mag[16:0]};
                mul_b = LN2_Q30;
                prod_next = mul_p;
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                mul_a = {15'd0, log_mag[33:17]};
                mul_b = LN2_Q30;
                lnv_next = log_int[6] ? $signed(-ln_full) : $signed(ln_full);
                step_next = '0;
                state_next = S_LN_ADD;
            end
            S_LN_ADD: begin
                if (step_reg == '1) begin
                    // Start of a component: offset, then the weight log.
                    acc_next = clamp48(-$signed(off));
                    if (in_reg.mix_weight == 32'd0) begin
                        inf_next = 1'b1;
                        state_next = S_VCHECK;
                    end else begin
                        inf_next = 1'b0;
                        m_next = in_reg.mix_weight;
                        e_next = 5'd31;
                        state_next = S_NORM;
                    end
                end else begin
                    acc_next = sat_add48(acc_reg, clamp48(rnd));
                    state_next = sel_reg ? S_MAG_SQ : S_VCHECK;
                end
            end
            S_MAG_SQ: begin
                mul_a = mag;
                mul_b = mag;
                num_next = 63'(mul_p + 64'(in_reg.inv_variance));
                den_next = {in_reg.inv_variance, 1'b0};
                rem_next = '0;
                step_next = '0;
                state_next = S_DIVIDE;
            end
            S_DIVIDE: begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = 33'(trial - {1'b0, den_reg});
                    num_next = {num_reg[61:0], 1'b1};
                end else begin
                    rem_next = trial[32:0];
                    num_next = {num_reg[61:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == DIV_LAST) begin
                    state_next = S_QUAD_ADD;
                end
            end
            S_QUAD_ADD: begin
                acc_next = sat_add48(acc_reg, -quad);
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!in_reg.last_elem) begin
                    state_next = S_IDLE;
                end else if (!out_valid_reg || m_ready) begin
                    out_next.minus_inf = inf_reg;
                    out_next.component_index = comp_reg;
                    if (inf_reg || acc_reg < -48'sd2147483648) begin
                        out_next.gauss_const = 32'sh8000_0000;
                    end else if (acc_reg > 48'sd2147483647) begin
                        out_next.gauss_const = 32'sh7FFF_FFFF;
                    end else begin
                        out_next.gauss_const = acc_reg[31:0];
                    end
                    out_valid_next = 1'b1;
                    comp_next = comp_reg + 16'd1;
                    acc_next = '0;
                    inf_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    `GMMGC_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")
    `GMMGC_ASSERT(a_result_origin, $rose(m_valid) |-> $past(state_reg == S_FINISH && in_reg.last_elem), "result without last item")
    `GMMGC_ASSERT(a_inf_value, m_valid && m_data.minus_inf |-> m_data.gauss_const == 32'sh8000_0000, "minus infinity value")
    `GMMGC_ASSERT(a_div_steps, state_reg == S_DIVIDE |-> step_reg <= DIV_LAST, "divider overrun")
endmodule

FILE: sv/gmmgc_mul.sv
// Shared unsigned 32 by 32 multiplier of the Gaussian constant block.
// No dependencies; the caller registers the product.
module gmmgc_mul (
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] product
);
    assign product = 64'(op_a) * 64'(op_b);
endmodule

FILE: tb/gmmgc_checker.sv
// Checker for the Gaussian constant block: predicts each constant from the accepted items.
// Depends on gmmgc_pkg; watches the input, result and configuration channels.
`timescale 1ns / 1ps
module gmmgc_checker
    import gmmgc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  gmmgc_in_t  s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  gmmgc_out_t m_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending
);

    localparam int FB = 16;
    localparam int DIM_MAX = 255;
    localparam logic signed [63:0] LN2 = 64'sd744261118;

    logic signed [63:0] sum_q;
    logic               inf_seen;
    logic [15:0]        comp_cnt;
    logic [7:0]         dim_reg;
    gmmgc_out_t         const_q[$];

    assign pending = const_q.size();

    function automatic logic signed [63:0] sat48(input logic signed [63:0] v);
        if (v > ACC_MAX64) return ACC_MAX64;
        if (v < ACC_MIN64) return ACC_MIN64;
        return v;
    endfunction

    // Arithmetic shift right with rounding half up.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int s);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    // Natural logarithm in Q58 of a nonzero x that carries fb fraction bits.
    function automatic logic signed [63:0] ln58(input logic [31:0] x, input int fb);
        int e;
        logic [63:0] m;
        logic signed [63:0] fr;
        e = 31;
        fr = 0;
        while (e > 0 && x[e] == 1'b0) e--;
        m = 64'(x) << (31 - e);
        for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            fr = fr <<< 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        return ((64'(signed'(e - fb)) <<< LOG_FRAC) + fr) * LN2;
    endfunction

    task automatic add_to_sum(input logic signed [63:0] t);
        sum_q = sat48(sum_q + sat48(t));
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        fail_count++;
    endtask

    task automatic predict(input gmmgc_in_t it);
        logic [63:0] dim, off, mag, sq, q;
        logic signed [63:0] r;
        gmmgc_out_t o;
        if (it.first_elem) begin
            dim = (dim_reg > 8'(DIM_MAX)) ? 64'(DIM_MAX) : 64'(dim_reg);
            off = (dim * 64'(HALF_LN_2PI_Q32) + (64'd1 << (31 - FB))) >> (32 - FB);
            sum_q = sat48(-$signed(off));
            inf_seen = 1'b0;
            if (it.mix_weight == 0) inf_seen = 1'b1;
            else add_to_sum(rnd_shift(ln58(it.mix_weight, 32), 58 - FB));
        end
        if (it.inv_variance == 0) begin
            inf_seen = 1'b1;
        end else begin
            mag = it.mean_times_invvar[31] ? 64'h1_0000_0000 - 64'(it.mean_times_invvar[31:0])
                                           : 64'(it.mean_times_invvar[31:0]);
            sq = mag * mag;
            q = (sq + it.inv_variance) / (2 * 64'(it.inv_variance));
            if (q > 64'(ACC_MAX64)) q = 64'(ACC_MAX64);
            add_to_sum(rnd_shift(ln58(it.inv_variance, FB), 59 - FB));
            add_to_sum(-$signed(q));
        end
        if (it.last_elem) begin
            if (inf_seen) r = -64'sd2147483648;
            else if (sum_q > 64'sd2147483647) r = 64'sd2147483647;
            else if (sum_q < -64'sd2147483648) r = -64'sd2147483648;
            else r = sum_q;
            o.gauss_const = r[31:0];
            o.minus_inf = inf_seen;
            o.component_index = comp_cnt;
            const_q = {const_q, o};
            comp_cnt++;
            sum_q = 0;
            inf_seen = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        gmmgc_out_t want;
        if (!aresetn) begin
            sum_q = 0;
            inf_seen = 1'b0;
            comp_cnt = 0;
            dim_reg = 8'd39;
            fail_count = 0;
            const_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) dim_reg = cfg_data;
            if (s_valid && s_ready) predict(s_data);
            if (m_valid && m_ready) begin
                if (const_q.size() == 0) begin
                    report("unexpected constant", 64'(m_data), 64'd0);
                end else begin
                    want = const_q.pop_front();
                    if (m_data.gauss_const !== want.gauss_const)
                        report("gauss_const", 64'(m_data.gauss_const),
                               64'(want.gauss_const));
                    if (m_data.minus_inf !== want.minus_inf)
                        report("minus_inf", 64'(m_data.minus_inf), 64'(want.minus_inf));
                    if (m_data.component_index !== want.component_index)
                        report("component_index", 64'(m_data.component_index),
                               64'(want.component_index));
                end
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the Gaussian constant block: drives items and configuration.
// Depends on gmmgc_pkg, gmm_gaussian_constant and gmmgc_checker.
`timescale 1ns / 1ps
module tb_top;
    import gmmgc_pkg::*;

    localparam int WATCHDOG = 200000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    gmmgc_in_t  s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    gmmgc_out_t m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;
    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    // Receiver behaviour: 0 random idling, 1 always ready, 2 long hold-off.
    int         rx_mode = 1;

    always #10 aclk = ~aclk;

    gmm_gaussian_constant u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    gmmgc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // The watchdog ends the run when nothing has moved on any channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The result side runs in its own process. In the hold-off mode it stays low for
    // a long stretch, so that the block finishes its item and then stalls its input.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_mode == 2) begin
            m_ready <= 1'b0;
            repeat (3000) @(negedge aclk);
            m_ready <= 1'b1;
            rx_mode = 0;
        end else if (rx_mode == 1) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 9);
        end
    end

    // Offers one item and holds it until the block accepts it. The item goes out at
    // the next falling edge, so that it never meets the drop of the previous one.
    task automatic send_elem(input logic fst, input logic lst, input logic [31:0] w,
                             input logic [31:0] v, input logic [31:0] m, input bit gaps);
        @(negedge aclk);
        if (gaps)
            while ($urandom_range(99) < 9) @(negedge aclk);
        s_data <= '{first_elem: fst, last_elem: lst, mix_weight: w,
                    inv_variance: v, mean_times_invvar: m};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Registers are written only once the block is idle and every expected constant
    // has come out.
    task automatic set_dim(input logic [7:0] d);
        while (pending != 0 || !s_ready) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_data <= d;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random 32-bit value, biased towards small and extreme magnitudes.
    function automatic logic [31:0] rnd_word();
        case ($urandom_range(5))
            0: return 32'($urandom_range(3));
            1: return 32'hFFFF_FFFF - 32'($urandom_range(3));
            2: return 32'($urandom_range(32'h0003_FFFF));
            3: return 32'h8000_0000 ^ 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    // A well-formed component of n elements with random content; zero fields are rare.
    task automatic send_component(input int n, input bit gaps);
        logic [31:0] w, v;
        for (int k = 0; k < n; k++) begin
            w = ($urandom_range(49) == 0) ? 32'd0 : rnd_word();
            v = ($urandom_range(49) == 0) ? 32'd0 : rnd_word();
            if (w == 0 && $urandom_range(1)) w = 32'h4000_0000;
            if (v == 0 && $urandom_range(1)) v = 32'h0001_0000;
            send_elem(k == 0, k == n - 1, w, v, rnd_word(), gaps);
        end
    endtask

    initial begin
        int sent;
        int n;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset dimension.
        send_elem(1, 1, 32'h8000_0000, 32'h0001_0000, 32'h0000_0000, 0);
        send_elem(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
        send_elem(1, 1, 32'h0000_0001, 32'h0000_0001, 32'h8000_0000, 0);
        send_elem(1, 1, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 0); // zero weight
        send_elem(1, 0, 32'h4000_0000, 32'h0000_0000, 32'hFFFF_0000, 0); // zero variance
        send_elem(0, 1, 32'h0, 32'h0002_0000, 32'h0000_8000, 0);
        // A first element in mid-component restarts the sum.
        send_elem(1, 0, 32'h1234_5678, 32'h0003_0000, 32'h0001_0000, 0);
        send_elem(1, 0, 32'h2000_0000, 32'h0000_4000, 32'hFFFE_0000, 0);
        send_elem(0, 1, 32'hFFFF_FFFF, 32'h0010_0000, 32'h7FFF_FFFF, 0);
        // An unmarked element after a result accumulates onto a cleared state.
        send_elem(0, 0, 32'h0, 32'h0000_8000, 32'h0000_1000, 0);
        send_elem(0, 1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0);
        set_dim(8'd1);
        send_elem(1, 1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 0);
        set_dim(8'd255);
        send_elem(1, 0, 32'h0000_0001, 32'h0000_0001, 32'h8000_0000, 0);
        send_elem(0, 1, 32'h0, 32'h0000_0001, 32'h8000_0000, 0);

        // Random part: mostly well-formed components, some stray elements.
        sent = 14;
        rx_mode = 0;
        while (sent < 1500) begin
            if (sent > 300 && sent < 320) rx_mode = 2;
            if ($urandom_range(99) < 3) begin
                set_dim($urandom_range(3) == 0 ? 8'($urandom_range(1, 255)) :
                        8'($urandom_range(1, 8)));
            end
            if ($urandom_range(9) == 0) begin
                send_elem(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom,
                          $urandom, 1);
                sent++;
            end else begin
                n = $urandom_range(1, 4);
                // A long stretch with no idling on the sender side.
                send_component(n, !(sent > 700 && sent < 900));
                sent += n;
            end
            if (sent > 700 && sent < 900) rx_mode = (rx_mode == 2) ? 2 : 1;
            else if (rx_mode == 1) rx_mode = 0;
        end
        set_dim(8'd39);

        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
